// File: hdl/elc_pkg.sv
// elc_pkg: shared types and constants of the elevator controller
// no dependencies; used by the call picker, the top level and the checker
package elc_pkg;

    // request kinds
    localparam logic [2:0] KIND_MOTION = 3'd0;
    localparam logic [2:0] KIND_IDLE   = 3'd1;
    localparam logic [2:0] KIND_CALL   = 3'd2;
    localparam logic [2:0] KIND_IN     = 3'd3;
    localparam logic [2:0] KIND_OUT    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_DOOR_TICKS   = 3'd0;
    localparam logic [2:0] CFG_IDLE_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_MAX_RIDERS   = 3'd2;
    localparam logic [2:0] CFG_MOVE_STEP    = 3'd3;
    localparam logic [2:0] CFG_FLOOR_HEIGHT = 3'd4;

    // configuration reset values
    localparam logic [7:0] RST_DOOR_TICKS   = 8'd180;
    localparam logic [3:0] RST_IDLE_LIMIT   = 4'd5;
    localparam logic [3:0] RST_MAX_RIDERS   = 4'd8;
    localparam logic [5:0] RST_MOVE_STEP    = 6'd5;
    localparam logic [7:0] RST_FLOOR_HEIGHT = 8'd240;

    // mode codes as seen on the result channel
    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_UP   = 2'd1;
    localparam logic [1:0] MODE_CODE_DOWN = 2'd2;
    localparam logic [1:0] MODE_CODE_OPEN = 2'd3;

    localparam int HEIGHT_W = 12;

    typedef enum logic [3:0] {
        CAR_IDLE = 4'b0001,
        CAR_UP   = 4'b0010,
        CAR_DOWN = 4'b0100,
        CAR_OPEN = 4'b1000
    } car_mode_t;

    typedef struct packed {
        logic       found;
        logic [3:0] floor;
    } pick_t;

    function automatic logic [1:0] mode_code(input car_mode_t m);
        logic [1:0] code;
        unique case (m)
            CAR_IDLE: code = MODE_CODE_IDLE;
            CAR_UP:   code = MODE_CODE_UP;
            CAR_DOWN: code = MODE_CODE_DOWN;
            CAR_OPEN: code = MODE_CODE_OPEN;
            default:  code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/elc_if.sv
// elc_if: request and result channels of the elevator controller
// valid/ready handshake with payload; depends on nothing but the field widths
interface elc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] call_floor;

    modport source (output valid, output kind, output call_floor, input ready);
    modport sink   (input valid, input kind, input call_floor, output ready);
endinterface

interface elc_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  floor_now;
    logic [3:0]  riders;
    logic [4:0]  pending_calls;
    logic [11:0] car_height;
    logic        full_reject;

    modport source (output valid, output mode, output floor_now, output riders,
                    output pending_calls, output car_height, output full_reject,
                    input ready);
    modport sink   (input valid, input mode, input floor_now, input riders,
                    input pending_calls, input car_height, input full_reject,
                    output ready);
endinterface

// File: hdl/elevator_controller_unit.sv
// elevator_controller_unit: single-car controller, one result per request
// the result is registered and valid in the cycle after the request is taken
// throughput: one request per cycle while the result side is not stalled; the state register loop closes in that cycle
// the result register frees the request side whenever it is empty or being taken
// reset (rst_n low, asynchronous): car idle at ground, no calls, no riders,
// configuration back to defaults; depends on elc_pkg, elc_if, elc_call_pick
module elevator_controller_unit #(
    parameter int FLOORS = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_idx,
    input  logic [7:0] cfg_data,
    elc_req_if.sink    req,
    elc_res_if.source  res
);

    // configuration
    logic [7:0] door_ticks_reg;
    logic [3:0] idle_limit_reg;
    logic [3:0] max_riders_reg;
    logic [5:0] move_step_reg;
    logic [7:0] floor_height_reg;

    // car state
    elc_pkg::car_mode_t   mode_reg, mode_next;
    logic [3:0]           floor_reg, floor_next;
    logic [3:0]           target_reg, target_next;
    logic [11:0]          height_reg, height_next;
    logic [FLOORS-1:0]    mask_reg, mask_next;
    logic [3:0]           riders_reg, riders_next;
    logic [7:0]           door_cnt_reg, door_cnt_next;
    logic [3:0]           idle_cnt_reg, idle_cnt_next;
    logic                 reject;

    // result register
    logic        res_valid_reg;
    logic [1:0]  res_mode_reg;
    logic [3:0]  res_floor_reg;
    logic [3:0]  res_riders_reg;
    logic [4:0]  res_calls_reg;
    logic [11:0] res_height_reg;
    logic        res_reject_reg;

    logic              accept;
    elc_pkg::pick_t    pick;
    logic [11:0]       goal;
    logic [12:0]       up_height;
    logic [12:0]       down_limit;
    logic [3:0]        idle_inc;
    logic [15:0]       mask_wide;

    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    elc_call_pick #(
        .FLOORS (FLOORS)
    ) u_pick (
        .mask (mask_reg),
        .cur  (floor_reg),
        .pick (pick)
    );

    assign goal       = {8'd0, target_reg} * {4'd0, floor_height_reg};
    assign up_height  = {1'b0, height_reg} + {7'd0, move_step_reg};
    assign down_limit = {1'b0, goal} + {7'd0, move_step_reg};
    assign idle_inc   = idle_cnt_reg + 4'd1;

    always_comb
    begin
        mode_next     = mode_reg;
        floor_next    = floor_reg;
        target_next   = target_reg;
        height_next   = height_reg;
        mask_next     = mask_reg;
        riders_next   = riders_reg;
        door_cnt_next = door_cnt_reg;
        idle_cnt_next = idle_cnt_reg;
        reject        = 1'b0;

        unique case (req.kind)
            elc_pkg::KIND_MOTION:
            begin
                unique case (mode_reg)
                    elc_pkg::CAR_IDLE:
                    begin
                        if (pick.found)
                        begin
                            for (int f = 0; f < FLOORS; f++)
                            begin
                                if (pick.floor == 4'(f))
                                    mask_next[f] = 1'b0;
                            end
                            if (pick.floor == floor_reg)
                            begin
                                mode_next     = elc_pkg::CAR_OPEN;
                                door_cnt_next = door_ticks_reg;
                            end
                            else
                            begin
                                target_next = pick.floor;
                                mode_next   = (pick.floor > floor_reg) ? elc_pkg::CAR_UP
                                                                       : elc_pkg::CAR_DOWN;
                            end
                        end
                    end
                    elc_pkg::CAR_UP:
                    begin
                        if (up_height >= {1'b0, goal})
                        begin
                            height_next   = goal;
                            floor_next    = target_reg;
                            mode_next     = elc_pkg::CAR_OPEN;
                            door_cnt_next = door_ticks_reg;
                        end
                        else
                            height_next = up_height[11:0];
                    end
                    elc_pkg::CAR_DOWN:
                    begin
                        if ({1'b0, height_reg} <= down_limit)
                        begin
                            height_next   = goal;
                            floor_next    = target_reg;
                            mode_next     = elc_pkg::CAR_OPEN;
                            door_cnt_next = door_ticks_reg;
                        end
                        else
                            height_next = height_reg - {6'd0, move_step_reg};
                    end
                    elc_pkg::CAR_OPEN:
                    begin
                        if (door_cnt_reg <= 8'd1)
                        begin
                            door_cnt_next = '0;
                            mode_next     = elc_pkg::CAR_IDLE;
                        end
                        else
                            door_cnt_next = door_cnt_reg - 8'd1;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            elc_pkg::KIND_IDLE:
            begin
                if ((mode_reg == elc_pkg::CAR_IDLE) && (riders_reg == 4'd0)
                    && (floor_reg != 4'd0))
                begin
                    if (idle_inc >= idle_limit_reg)
                    begin
                        mask_next[0]  = 1'b1;
                        idle_cnt_next = '0;
                    end
                    else
                        idle_cnt_next = idle_inc;
                end
                else
                    idle_cnt_next = '0;
            end
            elc_pkg::KIND_CALL:
            begin
                for (int f = 0; f < FLOORS; f++)
                begin
                    if (req.call_floor == 4'(f))
                    begin
                        mask_next[f]  = 1'b1;
                        idle_cnt_next = '0;
                    end
                end
            end
            elc_pkg::KIND_IN:
            begin
                if (mode_reg == elc_pkg::CAR_OPEN)
                begin
                    if (riders_reg < max_riders_reg)
                    begin
                        riders_next   = riders_reg + 4'd1;
                        idle_cnt_next = '0;
                    end
                    else
                        reject = 1'b1;
                end
            end
            elc_pkg::KIND_OUT:
            begin
                if ((mode_reg == elc_pkg::CAR_OPEN) && (riders_reg != 4'd0))
                begin
                    riders_next   = riders_reg - 4'd1;
                    idle_cnt_next = '0;
                end
            end
            default:
            begin
                reject = 1'b0;
            end
        endcase
    end

    assign mask_wide = 16'(mask_next);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_ticks_reg   <= elc_pkg::RST_DOOR_TICKS;
            idle_limit_reg   <= elc_pkg::RST_IDLE_LIMIT;
            max_riders_reg   <= elc_pkg::RST_MAX_RIDERS;
            move_step_reg    <= elc_pkg::RST_MOVE_STEP;
            floor_height_reg <= elc_pkg::RST_FLOOR_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                elc_pkg::CFG_DOOR_TICKS:   door_ticks_reg   <= cfg_data;
                elc_pkg::CFG_IDLE_LIMIT:   idle_limit_reg   <= cfg_data[3:0];
                elc_pkg::CFG_MAX_RIDERS:   max_riders_reg   <= cfg_data[3:0];
                elc_pkg::CFG_MOVE_STEP:    move_step_reg    <= cfg_data[5:0];
                elc_pkg::CFG_FLOOR_HEIGHT: floor_height_reg <= cfg_data;
                default:                   door_ticks_reg   <= door_ticks_reg;
            endcase
        end
    end

    // car state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= elc_pkg::CAR_IDLE;
            floor_reg    <= '0;
            target_reg   <= '0;
            height_reg   <= '0;
            mask_reg     <= '0;
            riders_reg   <= '0;
            door_cnt_reg <= '0;
            idle_cnt_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            floor_reg    <= floor_next;
            target_reg   <= target_next;
            height_reg   <= height_next;
            mask_reg     <= mask_next;
            riders_reg   <= riders_next;
            door_cnt_reg <= door_cnt_next;
            idle_cnt_reg <= idle_cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_mode_reg   <= elc_pkg::mode_code(mode_next);
            res_floor_reg  <= floor_next;
            res_riders_reg <= riders_next;
            res_calls_reg  <= mask_wide[4:0];
            res_height_reg <= height_next;
            res_reject_reg <= reject;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.mode          = res_mode_reg;
    assign res.floor_now     = res_floor_reg;
    assign res.riders        = res_riders_reg;
    assign res.pending_calls = res_calls_reg;
    assign res.car_height    = res_height_reg;
    assign res.full_reject   = res_reject_reg;

endmodule

// File: hdl/elc_call_pick.sv
// elc_call_pick: nearest pending call to the current floor, ties to the lower floor
// depends on elc_pkg (pick_t)
module elc_call_pick #(
    parameter int FLOORS = 5
) (
    input  logic [FLOORS-1:0] mask,
    input  logic [3:0]        cur,
    output elc_pkg::pick_t    pick
);

    logic       lo_found;
    logic [3:0] lo_floor;
    logic       hi_found;
    logic [3:0] hi_floor;
    logic [3:0] lo_dist;
    logic [3:0] hi_dist;

    // highest call at or below the car
    always_comb
    begin
        lo_found = 1'b0;
        lo_floor = '0;
        for (int f = 0; f < FLOORS; f++)
        begin
            if (mask[f] && (4'(f) <= cur))
            begin
                lo_found = 1'b1;
                lo_floor = 4'(f);
            end
        end
    end

    // lowest call above the car
    always_comb
    begin
        hi_found = 1'b0;
        hi_floor = '0;
        for (int f = FLOORS - 1; f >= 0; f--)
        begin
            if (mask[f] && (4'(f) > cur))
            begin
                hi_found = 1'b1;
                hi_floor = 4'(f);
            end
        end
    end

    assign lo_dist = cur - lo_floor;
    assign hi_dist = hi_floor - cur;

    always_comb
    begin
        pick.found = lo_found || hi_found;
        if (lo_found && (!hi_found || (lo_dist <= hi_dist)))
            pick.floor = lo_floor;
        else
            pick.floor = hi_floor;
    end

endmodule

// File: hdl/elc_checker.sv
// elc_checker: port-level checks on the elevator controller over time
// depends on elc_pkg; bound to elevator_controller_unit below
module elc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_mode,
    input logic [3:0] res_riders,
    input logic [4:0] res_calls,
    input logic       res_reject
);

    // a taken request always yields a result in the next cycle
    a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> res_valid)
        else $error("request taken without a result one cycle later");

    // a refused boarding only happens with the doors open
    a_reject_open: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reject) |-> (res_mode == elc_pkg::MODE_CODE_OPEN))
        else $error("full_reject shown with the doors closed");

    // an empty or draining result stage never blocks requests
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid || res_ready) |-> req_ready)
        else $error("request side stalled with a free result stage");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_mode) && $stable(res_riders) && $stable(res_calls)))
        else $error("stalled result changed");

endmodule

bind elevator_controller_unit elc_checker u_elc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_mode   (res.mode),
    .res_riders (res.riders),
    .res_calls  (res.pending_calls),
    .res_reject (res.full_reject)
);
